FILE: rtl/core/ac_status_frame_receiver_core_assert.svh
// Assertion macros for the status frame receiver.
// Each macro checks on the rising edge of the given clock and is disabled
// while the given active-low reset is asserted.
`ifndef AC_STATUS_FRAME_RECEIVER_CORE_ASSERT_SVH
`define AC_STATUS_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ACSFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("acsfr assertion failed");

// The condition must never be true outside reset.
`define ACSFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("acsfr forbidden condition seen");

`else

`define ACSFR_ASSERT(lbl, clk, rst_n, prop)
`define ACSFR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/acsfr_pkg.sv
package acsfr_pkg;

  // Header and decode constants.
  localparam logic [7:0] HdrFirst   = 8'h55;
  localparam logic [7:0] HdrSecondA = 8'hAA;
  localparam logic [7:0] HdrSecondB = 8'h03;
  localparam logic [7:0] ModeCool   = 8'h01;
  localparam logic [7:0] PowerMask  = 8'h80;

  // Byte positions within a frame.
  localparam logic [3:0] BodyStartIdx    = 4'd2;
  localparam logic [3:0] FirstPayloadIdx = 4'd3;
  localparam logic [3:0] CheckIdx        = 4'd10;

  // Frame bytes 3 to 9 are kept.
  localparam int unsigned NumPayload = 7;

  typedef enum logic [2:0] {
    PhHunt   = 3'b001,
    PhSecond = 3'b010,
    PhBody   = 3'b100
  } acsfr_phase_e;

  // Fields decoded from the buffered frame bytes, plus the check result.
  typedef struct packed {
    logic       ok;
    logic [7:0] mode;
    logic [7:0] temperature;
    logic [7:0] fan;
    logic       power;
    logic       compressor;
    logic [7:0] error;
  } acsfr_frame_t;

  // Stored air-conditioner status.
  typedef struct packed {
    logic [7:0] temperature;
    logic [7:0] fan;
    logic [7:0] mode;
    logic       power;
    logic       compressor;
    logic [7:0] error;
  } acsfr_status_t;

endpackage

FILE: rtl/core/ac_status_frame_receiver_core.sv
// Result path: a check byte is held in the input register, and its result is then written into the result register.
// Throughput: one byte per cycle; only a check byte waits, and only while the
// previous result is still held on the output and not taken.
// Reset: asynchronous and active low; the receiver hunts for a header and all
// stored status fields read as zero. Buffered frame bytes are not cleared.
`include "ac_status_frame_receiver_core_assert.svh"

module ac_status_frame_receiver_core import acsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_ok_o,
  output logic [7:0] temperature_o,
  output logic [7:0] fan_speed_o,
  output logic [7:0] op_mode_o,
  output logic       power_on_o,
  output logic       compressor_on_o,
  output logic [7:0] error_code_o
);

  // The input register holds one byte request. The byte is processed from that
  // register, a check byte only once the result register is free, and at a frame end the outcome is written
  // into the result register, which holds it until the consumer takes it.

  logic          s0_valid_q, s0_valid_d;
  logic [7:0]    s0_byte_q;
  logic          in_fire;
  logic          advance;
  logic          frame_end;
  logic          load_res;
  logic          status_upd;
  acsfr_frame_t  frame;
  acsfr_status_t status_next;
  acsfr_status_t status_cur;

  logic          out_valid_q, out_valid_d;
  logic          out_ok_q;
  acsfr_status_t out_status_q;

  // A byte that is not a check byte never produces a result, so it may be
  // processed even while the result register is occupied.
  assign advance    = s0_valid_q && (!frame_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_res   = advance && frame_end;
  assign status_upd = load_res && frame.ok;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_fire) begin
      s0_valid_d = 1'b1;
    end else if (advance) begin
      s0_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_byte_q <= rx_byte_i;
    end
  end

  // The result carries the status as it stands after this frame, so the
  // result register takes the next value of the status register.
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_ok_q     <= frame.ok;
      out_status_q <= status_next;
    end
  end

  acsfr_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (s0_byte_q),
    .frame_end_o (frame_end),
    .frame_o     (frame)
  );

  acsfr_status u_status (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (status_upd),
    .frame_i       (frame),
    .status_next_o (status_next),
    .status_o      (status_cur)
  );

  assign out_valid_o     = out_valid_q;
  assign frame_ok_o      = out_ok_q;
  assign temperature_o   = out_status_q.temperature;
  assign fan_speed_o     = out_status_q.fan;
  assign op_mode_o       = out_status_q.mode;
  assign power_on_o      = out_status_q.power;
  assign compressor_on_o = out_status_q.compressor;
  assign error_code_o    = out_status_q.error;

  // A pending result must never be overwritten by a new frame end.
  `ACSFR_ASSERT_NEVER(a_no_result_overwrite, clk_i, rst_ni, load_res && out_valid_q && !out_ready_i)

  // A result only appears after a check byte was processed.
  `ACSFR_ASSERT(a_result_from_frame_end, clk_i, rst_ni, $rose(out_valid_q) |-> $past(load_res))

  // A good cool-mode frame reports cool mode.
  `ACSFR_ASSERT(a_cool_mode_stored, clk_i, rst_ni, (load_res && frame.ok && frame.mode == ModeCool) |=> (out_status_q.mode == ModeCool))

  // A failed frame reports the status unchanged.
  `ACSFR_ASSERT(a_failed_frame_holds, clk_i, rst_ni, (load_res && !frame.ok) |=> (out_status_q == $past(status_cur)))

endmodule

FILE: rtl/core/acsfr_framer.sv
module acsfr_framer import acsfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         frame_end_o,
  output acsfr_frame_t frame_o
);

  acsfr_phase_e phase_q, phase_d;
  logic [3:0]   idx_q, idx_d;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   sum_next;
  logic [2:0]   slot;
  logic         wr_en;
  logic [7:0]   frame_bytes_q [NumPayload];

  assign sum_next    = sum_q + byte_i;
  assign slot        = 3'(idx_q - FirstPayloadIdx);
  // The check byte is the one that arrives when the index reaches ten.
  assign frame_end_o = (phase_q == PhBody) && !(idx_q < CheckIdx);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    wr_en   = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PhSecond: begin
          if ((byte_i == HdrSecondA) || (byte_i == HdrSecondB)) begin
            sum_d   = HdrFirst + byte_i;
            idx_d   = BodyStartIdx;
            phase_d = PhBody;
          end else if (byte_i == HdrFirst) begin
            phase_d = PhSecond;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhBody: begin
          if (idx_q < CheckIdx) begin
            wr_en = (idx_q >= FirstPayloadIdx);
            sum_d = sum_next;
            idx_d = idx_q + 4'd1;
          end else begin
            phase_d = PhHunt;
            idx_d   = '0;
            sum_d   = '0;
          end
        end
        default: begin
          phase_d = (byte_i == HdrFirst) ? PhSecond : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_bytes_q[slot] <= byte_i;
    end
  end

  // A frame whose running sum is zero before the check byte is rejected.
  assign frame_o.ok          = (sum_q != 8'd0) && (sum_next == 8'd0);
  assign frame_o.compressor  = (frame_bytes_q[0] != 8'd0);
  assign frame_o.mode        = frame_bytes_q[1];
  assign frame_o.temperature = frame_bytes_q[2];
  assign frame_o.fan         = frame_bytes_q[3];
  assign frame_o.power       = |(frame_bytes_q[4] & PowerMask);
  assign frame_o.error       = frame_bytes_q[6];

endmodule

FILE: rtl/core/acsfr_status.sv
module acsfr_status import acsfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          update_i,
  input  acsfr_frame_t  frame_i,
  output acsfr_status_t status_next_o,
  output acsfr_status_t status_o
);

  acsfr_status_t status_q, status_d;

  // Setpoint, fan and mode follow the frame only in cool mode.
  always_comb begin
    status_d = status_q;
    if (update_i) begin
      if (frame_i.mode == ModeCool) begin
        status_d.temperature = frame_i.temperature;
        status_d.fan         = frame_i.fan;
        status_d.mode        = frame_i.mode;
      end
      status_d.power      = frame_i.power;
      status_d.compressor = frame_i.compressor;
      status_d.error      = frame_i.error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
    end else begin
      status_q <= status_d;
    end
  end

  assign status_next_o = status_d;
  assign status_o      = status_q;

endmodule
